// ----- rtl/pld_pkg.sv -----
// shared types and codes for the polynomial long divider
package pld_pkg;

  typedef enum logic [2:0] {
    ST_LOAD,
    ST_CHECK,
    ST_DIV,
    ST_MUL,
    ST_SUB,
    ST_SHIFT,
    ST_EMIT
  } state_t;

  typedef enum logic [1:0] {
    STAT_OK        = 2'd0,
    STAT_ZERO_LEAD = 2'd1,
    STAT_SHORT     = 2'd2,
    STAT_SAT       = 2'd3
  } stat_t;

  localparam logic CMD_DIVISOR  = 1'b0;
  localparam logic CMD_DIVIDEND = 1'b1;

  localparam logic PART_QUOT = 1'b0;
  localparam logic PART_REM  = 1'b1;

  localparam int COEFF_W = 32;

  // per-cell controls from the sequencer
  typedef struct packed {
    logic load_rem;
    logic load_dvs;
    logic mul;
    logic sub;
    logic shift;
  } cell_ctl_t;

endpackage

// ----- rtl/pld_if.sv -----
// valid/ready channel interfaces for input items and results
interface pld_in_if;
  logic               valid;
  logic               ready;
  logic               cmd;
  logic signed [31:0] coeff;
  logic               last_term;

  modport source (output valid, cmd, coeff, last_term, input ready);
  modport sink (input valid, cmd, coeff, last_term, output ready);
endinterface

interface pld_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] result_coeff;
  logic               part;
  logic [1:0]         status;
  logic               last_result;

  modport source (output valid, result_coeff, part, status, last_result, input ready);
  modport sink (input valid, result_coeff, part, status, last_result, output ready);
endinterface

// ----- rtl/pld_divider.sv -----
// bit-serial signed divider for one quotient term, saturated to 32 bits
module pld_divider
  import pld_pkg::*;
#(
  parameter int FRAC_BITS = 16
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic signed [31:0] num,
  input  logic signed [31:0] den,
  output logic               done,
  output logic signed [31:0] quot,
  output logic               sat
);

  localparam int NW = COEFF_W + FRAC_BITS;
  localparam int CW = $clog2(NW + 1);

  logic          busy;
  logic          fin;
  logic [CW-1:0] cnt;
  logic [31:0]   acc;
  logic [NW-1:0] qr;
  logic [31:0]   dmag;
  logic          neg;
  logic [32:0]   trial;
  logic [31:0]   nmag;

  assign nmag  = num[31] ? 32'(-num) : 32'(num);
  assign trial = {acc, qr[NW-1]} - {1'b0, dmag};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      fin  <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      fin  <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= CW'(NW);
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == CW'(1)) begin
          busy <= 1'b0;
          fin  <= 1'b1;
        end
      end
      if (fin) begin
        done <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      acc  <= '0;
      qr   <= {nmag, {FRAC_BITS{1'b0}}};
      dmag <= den[31] ? 32'(-den) : 32'(den);
      neg  <= num[31] ^ den[31];
    end else if (busy) begin
      // restoring step: one quotient bit per cycle
      if (!trial[32]) begin
        acc <= trial[31:0];
        qr  <= {qr[NW-2:0], 1'b1};
      end else begin
        acc <= {acc[30:0], qr[NW-1]};
        qr  <= {qr[NW-2:0], 1'b0};
      end
    end
    if (fin) begin
      if (neg) begin
        if (qr > NW'(33'h0_8000_0000)) begin
          quot <= 32'sh8000_0000;
          sat  <= 1'b1;
        end else begin
          quot <= 32'(-qr[31:0]);
          sat  <= 1'b0;
        end
      end else begin
        if (qr > NW'(33'h0_7fff_ffff)) begin
          quot <= 32'sh7fff_ffff;
          sat  <= 1'b1;
        end else begin
          quot <= qr[31:0];
          sat  <= 1'b0;
        end
      end
    end
  end

endmodule

// ----- rtl/pld_cell.sv -----
// one cell of the chain: a divisor term, a remainder term and its multiply-subtract
module pld_cell
  import pld_pkg::*;
#(
  parameter int FRAC_BITS = 16
) (
  input  logic               clk,
  input  cell_ctl_t          ctl,
  input  logic signed [31:0] coeff_in,
  input  logic signed [31:0] t,
  input  logic signed [31:0] shift_in,
  output logic signed [31:0] rem,
  output logic signed [31:0] dvs,
  output logic               ovf
);

  localparam int R_W = 65 - FRAC_BITS;

  logic signed [63:0]  prod;
  logic signed [64:0]  rsum;
  logic signed [R_W-1:0] rnd;
  logic signed [R_W:0] diff;
  logic                out_of_range;

  // round to nearest, ties up, then floor shift
  assign rsum = {prod[63], prod} + 65'(1 << (FRAC_BITS - 1));
  assign rnd  = $signed(rsum[64:FRAC_BITS]);
  assign diff = $signed({{(R_W - 31){rem[31]}}, rem}) - $signed({rnd[R_W-1], rnd});
  assign out_of_range = !((&diff[R_W:31]) || !(|diff[R_W:31]));
  assign ovf  = ctl.sub & out_of_range;

  always_ff @(posedge clk) begin
    if (ctl.load_dvs) begin
      dvs <= coeff_in;
    end
    if (ctl.mul) begin
      prod <= t * dvs;
    end
    if (ctl.load_rem) begin
      rem <= coeff_in;
    end else if (ctl.sub) begin
      if (out_of_range) begin
        rem <= diff[R_W] ? 32'sh8000_0000 : 32'sh7fff_ffff;
      end else begin
        rem <= diff[31:0];
      end
    end else if (ctl.shift) begin
      rem <= shift_in;
    end
  end

endmodule

// ----- rtl/polynomial_long_divider_unit.sv -----
// Polynomial long divider over signed fixed-point coefficients (Q16.16 by default).
// Load items transfer one per cycle: divisor terms (cmd 0), then dividend terms (cmd 1),
// highest degree first, last_term closing each set; up to MAX_TERMS terms each, extras
// dropped. Terms sit in a chain of cells, one per degree. For each of the n-m+1 quotient
// terms a bit-serial divider runs, then every cell multiplies, the cells holding the
// divisor terms after the lead subtract, and the chain shifts by one term. After the
// division n results follow, one per cycle when the sink is ready: quotient terms first,
// then remainder terms. No input is taken during division or result output. A zero
// leading divisor term or a dividend shorter than the divisor gives one error result
// instead; any saturation marks every result of that division.
module polynomial_long_divider_unit
  import pld_pkg::*;
#(
  parameter int MAX_TERMS = 32,
  parameter int FRAC_BITS = 16
) (
  input  logic     clk,
  input  logic     rst,
  pld_in_if.sink   in_ch,
  pld_out_if.source out_ch
);

  localparam int CNT_W = $clog2(MAX_TERMS + 1);

  state_t state, state_next;

  logic [CNT_W-1:0] dcount;
  logic [CNT_W-1:0] ncount;
  logic [CNT_W-1:0] qcount;
  logic [CNT_W-1:0] step;
  logic [CNT_W-1:0] emit_idx;
  logic             closed;
  logic             sat_flag;

  logic             in_xfer;
  logic             out_free;
  logic             err_zero;
  logic             err_short;
  logic             div_start;
  logic             emit;
  logic             emit_err;

  logic               div_done;
  logic signed [31:0] div_quot;
  logic               div_sat;
  logic signed [31:0] div_num;
  logic signed [31:0] tq;

  logic signed [31:0] qchain [MAX_TERMS];
  logic signed [31:0] rem_arr [MAX_TERMS];
  logic signed [31:0] dvs_arr [MAX_TERMS];
  logic [MAX_TERMS-1:0] ovf_arr;
  cell_ctl_t            ctl [MAX_TERMS];

  logic               ovalid;
  logic signed [31:0] ocoeff;
  logic               opart;
  logic [1:0]         ostatus;
  logic               olast;

  assign in_ch.ready = (state == ST_LOAD);
  assign in_xfer     = in_ch.valid & in_ch.ready;
  assign out_free    = !ovalid | out_ch.ready;
  assign err_zero    = (dcount == '0) || (dvs_arr[0] == '0);
  assign err_short   = ncount < dcount;

  // during the shift the next lead is still one cell up
  assign div_num = (state == ST_SHIFT) ? rem_arr[1] : rem_arr[0];

  assign out_ch.valid        = ovalid;
  assign out_ch.result_coeff = ocoeff;
  assign out_ch.part         = opart;
  assign out_ch.status       = ostatus;
  assign out_ch.last_result  = olast;

  always_comb begin
    state_next = state;
    div_start  = 1'b0;
    emit       = 1'b0;
    emit_err   = 1'b0;
    unique case (state)
      ST_LOAD: begin
        if (in_xfer && in_ch.cmd == CMD_DIVIDEND && in_ch.last_term) begin
          state_next = ST_CHECK;
        end
      end
      ST_CHECK: begin
        if (err_zero || err_short) begin
          if (out_free) begin
            emit_err   = 1'b1;
            state_next = ST_LOAD;
          end
        end else begin
          div_start  = 1'b1;
          state_next = ST_DIV;
        end
      end
      ST_DIV: begin
        if (div_done) begin
          state_next = ST_MUL;
        end
      end
      ST_MUL: state_next = ST_SUB;
      ST_SUB: state_next = ST_SHIFT;
      ST_SHIFT: begin
        if (step + 1'b1 == qcount) begin
          state_next = ST_EMIT;
        end else begin
          div_start  = 1'b1;
          state_next = ST_DIV;
        end
      end
      ST_EMIT: begin
        if (out_free) begin
          emit = 1'b1;
          if (emit_idx + 1'b1 == ncount) begin
            state_next = ST_LOAD;
          end
        end
      end
      default: state_next = ST_LOAD;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_LOAD;
      dcount   <= '0;
      ncount   <= '0;
      closed   <= 1'b0;
      sat_flag <= 1'b0;
      ovalid   <= 1'b0;
    end else begin
      state <= state_next;
      if (in_xfer) begin
        if (in_ch.cmd == CMD_DIVISOR) begin
          if (closed) begin
            dcount <= CNT_W'(1);
          end else if (dcount < CNT_W'(MAX_TERMS)) begin
            dcount <= dcount + 1'b1;
          end
          closed <= in_ch.last_term;
        end else if (ncount < CNT_W'(MAX_TERMS)) begin
          ncount <= ncount + 1'b1;
        end
      end
      if (state == ST_CHECK) begin
        sat_flag <= 1'b0;
      end else if (div_done && div_sat) begin
        sat_flag <= 1'b1;
      end else if (state == ST_SUB && (|ovf_arr)) begin
        sat_flag <= 1'b1;
      end
      if (emit_err || (emit && emit_idx + 1'b1 == ncount)) begin
        dcount <= '0;
        ncount <= '0;
        closed <= 1'b0;
      end
      if (emit_err || emit) begin
        ovalid <= 1'b1;
      end else if (out_ch.ready) begin
        ovalid <= 1'b0;
      end
    end
  end

  // step and output bookkeeping
  always_ff @(posedge clk) begin
    if (div_start && state == ST_CHECK) begin
      step     <= '0;
      qcount   <= ncount - dcount + 1'b1;
      emit_idx <= '0;
    end else if (state == ST_SHIFT) begin
      step <= step + 1'b1;
    end
    if (emit) begin
      emit_idx <= emit_idx + 1'b1;
    end
    if (div_done) begin
      tq <= div_quot;
    end
    if (emit_err) begin
      ocoeff  <= '0;
      opart   <= PART_QUOT;
      ostatus <= err_zero ? STAT_ZERO_LEAD : STAT_SHORT;
      olast   <= 1'b1;
    end else if (emit) begin
      ostatus <= sat_flag ? STAT_SAT : STAT_OK;
      olast   <= (emit_idx + 1'b1 == ncount);
      if (emit_idx < qcount) begin
        ocoeff <= qchain[0];
        opart  <= PART_QUOT;
      end else begin
        ocoeff <= rem_arr[0];
        opart  <= PART_REM;
      end
    end
  end

  // quotient terms: written at their step, shifted out head first
  always_ff @(posedge clk) begin
    for (int k = 0; k < MAX_TERMS; k++) begin
      if (div_done && step == CNT_W'(k)) begin
        qchain[k] <= div_quot;
      end else if (emit && emit_idx < qcount) begin
        qchain[k] <= (k + 1 < MAX_TERMS) ? qchain[(k + 1) % MAX_TERMS] : '0;
      end
    end
  end

  always_comb begin
    for (int k = 0; k < MAX_TERMS; k++) begin
      ctl[k].load_dvs = in_xfer && in_ch.cmd == CMD_DIVISOR &&
                        (closed ? (k == 0) :
                         (dcount < CNT_W'(MAX_TERMS) && dcount == CNT_W'(k)));
      ctl[k].load_rem = in_xfer && in_ch.cmd == CMD_DIVIDEND &&
                        ncount < CNT_W'(MAX_TERMS) && ncount == CNT_W'(k);
      ctl[k].mul      = (state == ST_MUL);
      ctl[k].sub      = (state == ST_SUB) && k >= 1 && CNT_W'(k) < dcount;
      ctl[k].shift    = (state == ST_SHIFT) || (emit && emit_idx >= qcount);
    end
  end

  genvar g;
  generate
    for (g = 0; g < MAX_TERMS; g++) begin : g_cell
      logic signed [31:0] nb;
      if (g + 1 < MAX_TERMS) begin : g_mid
        assign nb = rem_arr[g+1];
      end else begin : g_end
        assign nb = '0;
      end
      pld_cell #(
        .FRAC_BITS(FRAC_BITS)
      ) u_cell (
        .clk     (clk),
        .ctl     (ctl[g]),
        .coeff_in(in_ch.coeff),
        .t       (tq),
        .shift_in(nb),
        .rem     (rem_arr[g]),
        .dvs     (dvs_arr[g]),
        .ovf     (ovf_arr[g])
      );
    end
  endgenerate

  pld_divider #(
    .FRAC_BITS(FRAC_BITS)
  ) u_div (
    .clk  (clk),
    .rst  (rst),
    .start(div_start),
    .num  (div_num),
    .den  (dvs_arr[0]),
    .done (div_done),
    .quot (div_quot),
    .sat  (div_sat)
  );

endmodule

// ----- rtl/pld_checker.sv -----
// port-level checks for the polynomial long divider, bound to the top level
module pld_checker
  import pld_pkg::*;
(
  input logic        clk,
  input logic        rst,
  input logic        in_valid,
  input logic        in_ready,
  input logic        in_cmd,
  input logic        in_last,
  input logic        out_valid,
  input logic        out_ready,
  input logic [31:0] out_coeff,
  input logic        out_part,
  input logic [1:0]  out_status,
  input logic        out_last
);

  // a stalled result holds
  assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_coeff) && $stable(out_last))
    else $error("result changed while stalled");

  // an error result is a lone zero quotient-side result
  assert property (@(posedge clk) disable iff (rst)
    out_valid && (out_status == STAT_ZERO_LEAD || out_status == STAT_SHORT) |->
    out_last && out_coeff == '0 && out_part == PART_QUOT)
    else $error("malformed error result");

  // remainder terms never carry an error code
  assert property (@(posedge clk) disable iff (rst)
    out_valid && out_part == PART_REM |->
    out_status != STAT_ZERO_LEAD && out_status != STAT_SHORT)
    else $error("remainder term with error status");

  // the closing dividend term ends loading; input is not ready right after it
  assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && in_cmd == CMD_DIVIDEND && in_last |=> !in_ready)
    else $error("input taken right after closing dividend term");

endmodule

bind polynomial_long_divider_unit pld_checker u_pld_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_ch.valid),
  .in_ready  (in_ch.ready),
  .in_cmd    (in_ch.cmd),
  .in_last   (in_ch.last_term),
  .out_valid (out_ch.valid),
  .out_ready (out_ch.ready),
  .out_coeff (out_ch.result_coeff),
  .out_part  (out_ch.part),
  .out_status(out_ch.status),
  .out_last  (out_ch.last_result)
);
